FILE: hw/rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = 2 * DATA_W;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [CNT_W-1:0]         fill_count;
        logic                     is_empty;
    } t_out;

    typedef struct packed {
        logic    push;
        logic    pop_clear;
        logic    pop_read;
        logic    pop_load;
        logic    load_out;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/mts_ram.sv
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mts_ctrl.sv
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_action,
    input  wire logic     i_stall,
    input  wire t_dp_stat i_stat,
    output logic          o_stall,
    output logic          o_valid,
    output t_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   can_take;

    assign can_take = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || !i_stall);
    assign o_stall  = !can_take;
    assign accept   = i_valid && can_take;
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_PUSH) begin
                        o_cmd.load_out = 1'b1;
                        if (i_stat.count_full) begin
                            o_cmd.status = ST_PUSH_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_stat.count_zero) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.status   = ST_POP_EMPTY;
                    end else if (i_stat.count_one) begin
                        o_cmd.load_out  = 1'b1;
                        o_cmd.pop_clear = 1'b1;
                    end else begin
                        o_cmd.pop_read = 1'b1;
                        n_state        = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.pop_load = 1'b1;
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mts_dp.sv
`default_nettype none

module mts_dp
    import mts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    input  wire t_cmd                     i_cmd,
    output t_dp_stat                      o_stat,
    output t_out                          o_result
);

    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic [CNT_W-1:0]         r_count, n_count;
    t_out                     r_res, n_res;

    logic [ENTRY_W-1:0]       rdata;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         cnt_m2;
    logic                     we;
    logic signed [DATA_W-1:0] push_min;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign waddr  = cnt_m1[ADDR_W-1:0];
    assign raddr  = cnt_m2[ADDR_W-1:0];

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CNT_W'(1));
    assign o_stat.count_full = (r_count == CNT_W'(STACK_DEPTH));

    assign we = i_cmd.push && !o_stat.count_zero;

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_top_val, r_top_min}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (!o_stat.count_zero && (r_top_min < i_push_value)) begin
            push_min = r_top_min;
        end else begin
            push_min = i_push_value;
        end
    end

    always_comb begin
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        n_count   = r_count;
        if (i_cmd.push) begin
            n_top_val = i_push_value;
            n_top_min = push_min;
            n_count   = r_count + CNT_W'(1);
        end else if (i_cmd.pop_clear) begin
            n_count = '0;
        end else if (i_cmd.pop_load) begin
            n_top_val = rdata[ENTRY_W-1:DATA_W];
            n_top_min = rdata[DATA_W-1:0];
            n_count   = cnt_m1;
        end
    end

    always_comb begin
        n_res            = r_res;
        if (i_cmd.load_out) begin
            n_res.status     = i_cmd.status;
            n_res.fill_count = n_count;
            n_res.is_empty   = (n_count == '0);
            if (n_count == '0) begin
                n_res.top_value = '0;
                n_res.min_value = '0;
            end else begin
                n_res.top_value = n_top_val;
                n_res.min_value = n_top_min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        r_res     <= n_res;
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: hw/rtl/min_tracking_stack_top.sv
// Stack of signed 32-bit values that also tracks the smallest value held.
// Input channel i_valid / o_stall carries one transaction of type t_in:
// action (push or pop) and push_value. Output channel o_valid / i_stall
// carries one t_out per input: status, top_value, min_value, fill_count and
// is_empty after the operation (top and minimum read 0 when empty).
// The top level lives in registers; the levels below it sit in a
// 64 x 64-bit stack RAM with registered read.
// A push, an error, or a pop that leaves the stack empty registers its
// result in the cycle after acceptance; a pop that leaves entries behind
// first reads the new top from the RAM in the fetch state, then loads it.
// One transaction per cycle, but no input is taken in the fetch state.
// Reset (i_rst_n low at a clock edge) empties the stack and drops any
// pending result; RAM contents are left as they are.
// While the receiver stalls, the result register holds its transaction and
// no new input is taken until it drains; a new input is taken in the same
// cycle that the pending result leaves.
`default_nettype none

module min_tracking_stack_top
    import mts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_item,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_result
);

    t_cmd     cmd;
    t_dp_stat stat;

    mts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_item.action),
        .i_stall  (i_stall),
        .i_stat   (stat),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    mts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_value (i_item.push_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_result     (o_result)
    );

    a_fetch_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop_read |=> cmd.pop_load)
        else $error("pop fetch not followed by load");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.fill_count <= CNT_W'(STACK_DEPTH)))
        else $error("fill count beyond depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_empty == (o_result.fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_PUSH_FULL))
            |-> (o_result.fill_count == CNT_W'(STACK_DEPTH)))
        else $error("push-full reported on non-full stack");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mts_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SEGMENTS     = 12;
    localparam int SEGMENT_OPS  = 80;
    localparam int QUIET_SEG    = 5;

    typedef enum logic [1:0] {
        RX_RANDOM,
        RX_QUIET,
        RX_HOLD
    } rx_mode_t;

    class stack_tracker;
        logic signed [DATA_W-1:0] level_value [STACK_DEPTH];
        logic signed [DATA_W-1:0] level_min   [STACK_DEPTH];
        int unsigned              depth_used;
        t_out                     pending_reports [$];
        int unsigned              bad_count;
        int unsigned              report_index;

        function new();
            depth_used   = 0;
            bad_count    = 0;
            report_index = 0;
        endfunction

        function void note_op(t_in op);
            t_out                     rep;
            logic signed [DATA_W-1:0] run_min;
            rep        = '0;
            rep.status = ST_OK;
            run_min    = $signed(op.push_value);
            if (op.action == ACT_PUSH) begin
                if (depth_used == STACK_DEPTH) begin
                    rep.status = ST_PUSH_FULL;
                end else begin
                    if (depth_used != 0 && $signed(level_min[depth_used-1]) < run_min)
                        run_min = level_min[depth_used-1];
                    level_value[depth_used] = op.push_value;
                    level_min[depth_used]   = run_min;
                    depth_used++;
                end
            end else if (depth_used == 0) begin
                rep.status = ST_POP_EMPTY;
            end else begin
                depth_used--;
            end
            if (depth_used != 0) begin
                rep.top_value = level_value[depth_used-1];
                rep.min_value = level_min[depth_used-1];
            end
            rep.fill_count = CNT_W'(depth_used);
            rep.is_empty   = (depth_used == 0);
            pending_reports.push_back(rep);
        endfunction

        function void check_report(t_out got);
            t_out want;
            report_index++;
            if (pending_reports.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("stack check: result %0d arrived with nothing pending: st=%0d top=%0d min=%0d fill=%0d empty=%0b",
                             report_index, got.status, got.top_value, got.min_value,
                             got.fill_count, got.is_empty);
                return;
            end
            want = pending_reports.pop_front();
            if (got.status !== want.status || got.top_value !== want.top_value ||
                got.min_value !== want.min_value || got.fill_count !== want.fill_count ||
                got.is_empty !== want.is_empty) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("stack check: result %0d mismatch", report_index);
                    $display("  want st=%0d top=%0d min=%0d fill=%0d empty=%0b",
                             want.status, want.top_value, want.min_value,
                             want.fill_count, want.is_empty);
                    $display("  got  st=%0d top=%0d min=%0d fill=%0d empty=%0b",
                             got.status, got.top_value, got.min_value,
                             got.fill_count, got.is_empty);
                end
            end
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_in      i_item  = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_out     o_result;
    rx_mode_t rx_mode = RX_RANDOM;

    stack_tracker tracker = new();

    min_tracking_stack_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                tracker.note_op(i_item);
            if (o_valid && !i_stall)
                tracker.check_report(o_result);
        end
    end

    initial begin : receiver
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (rx_mode == RX_HOLD && held < HOLD_CYCLES) begin
                i_stall <= 1'b1;
                held++;
            end else if (rx_mode == RX_RANDOM) begin
                i_stall <= ($urandom_range(99) < 15);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0:       return DATA_W'(int'($urandom_range(16)) - 8);
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in make_op(logic act, logic signed [DATA_W-1:0] value);
        t_in op;
        op.action     = act;
        op.push_value = value;
        return op;
    endfunction

    function automatic t_in random_op(int push_pct);
        return make_op(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP, pick_value());
    endfunction

    task automatic send_op(input t_in op, input bit may_idle);
        if (may_idle && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= op;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_in directed_ops [$];
        int  push_pct;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sh7fffffff));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sh80000000));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sd0));
        directed_ops.push_back(make_op(ACT_PUSH, -32'sd1));
        directed_ops.push_back(make_op(ACT_POP,  32'sh5a5a5a5a));
        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_POP,  32'shffffffff));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sh7fffffff));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sd5));
        directed_ops.push_back(make_op(ACT_PUSH, 32'sd5));
        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_POP,  32'sd0));
        directed_ops.push_back(make_op(ACT_POP,  32'sh80000000));
        directed_ops.push_back(make_op(ACT_PUSH, -32'sd1));
        directed_ops.push_back(make_op(ACT_POP,  32'sh7fffffff));
        foreach (directed_ops[k])
            send_op(directed_ops[k], 1'b1);
        wait_drained();

        // fill to the top, overflow twice, then drain past empty
        repeat (STACK_DEPTH + 2) send_op(make_op(ACT_PUSH, pick_value()), 1'b1);
        repeat (STACK_DEPTH + 1) send_op(make_op(ACT_POP, pick_value()), 1'b1);
        wait_drained();

        rx_mode <= RX_HOLD;
        repeat (40) send_op(random_op(70), 1'b1);
        wait_drained();
        rx_mode <= RX_RANDOM;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(4))
                0:       push_pct = 25;
                1:       push_pct = 50;
                2:       push_pct = 65;
                3:       push_pct = 80;
                default: push_pct = 95;
            endcase
            rx_mode <= (seg == QUIET_SEG) ? RX_QUIET : RX_RANDOM;
            repeat (SEGMENT_OPS) send_op(random_op(push_pct), seg != QUIET_SEG);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.pending_reports.size() != 0)
            $display("stack check: %0d results never arrived", tracker.pending_reports.size());
        if (tracker.bad_count == 0 && tracker.pending_reports.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
